// ===== src/mi_pkg.sv =====
`default_nettype none
package mi_pkg;

	localparam int EW = 32;
	localparam int FB = 16;

	localparam int PW = 2 * EW;
	localparam int PPW = 2 * EW + 1;
	localparam int CRW = 2 * EW + 1;
	localparam int CRMW = 2 * EW;
	localparam int DETW = 3 * EW + 3;
	localparam int DMW = DETW - 1;
	localparam int NUMW = CRMW + 2 * FB;
	localparam int QW = EW + 1;
	localparam int RW = DMW - 2 * FB + 1;

	localparam int FRONT_ST = 5;
	localparam int LANE_ST = QW + 2;
	localparam int NST = FRONT_ST + LANE_ST;

	typedef logic signed [EW-1:0] elem_t;
	typedef elem_t mat_t [9];
	typedef logic signed [CRW-1:0] cr_t;
	typedef logic signed [DETW-1:0] det_t;

	typedef struct packed {
		logic sing;
		logic dsat;
		logic [EW-1:0] dval;
	} side_t;

endpackage
`default_nettype wire

// ===== src/mi_ifs.sv =====
`default_nettype none
interface mi_mat_if;
	import mi_pkg::*;
	logic valid;
	logic ready;
	elem_t a00, a01, a02, a10, a11, a12, a20, a21, a22;
	modport source (output valid, a00, a01, a02, a10, a11, a12, a20, a21, a22,
		input ready);
	modport sink (input valid, a00, a01, a02, a10, a11, a12, a20, a21, a22,
		output ready);
endinterface

interface mi_res_if;
	import mi_pkg::*;
	logic valid;
	logic ready;
	elem_t i00, i01, i02, i10, i11, i12, i20, i21, i22;
	elem_t det_value;
	logic singular;
	logic saturated;
	modport source (output valid, i00, i01, i02, i10, i11, i12, i20, i21, i22,
		det_value, singular, saturated, input ready);
	modport sink (input valid, i00, i01, i02, i10, i11, i12, i20, i21, i22,
		det_value, singular, saturated, output ready);
endinterface
`default_nettype wire

// ===== src/matrix3x3_inverse_determinant.sv =====
// 3x3 matrix inverse and determinant, Q16.16 signed. One matrix beat is taken
// every clock cycle unless a full pipeline is held by a stalled output. The
// multiply and cross-product stages form the exact determinant, then nine
// divider lanes (one per inverse element) each resolve one quotient bit a
// cycle over 33 stages while not held, plus one stage to set up and one to
// round and clip. A stalled output only holds stages that are full, so empty
// stages keep taking beats. The singularity threshold resets to 1; a singular
// matrix gives an all-zero inverse.
`default_nettype none
module matrix3x3_inverse_determinant (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [mi_pkg::EW-2:0] cfg_data,
	mi_mat_if.sink                    mat,
	mi_res_if.source                  res
);
	import mi_pkg::*;

	logic [EW-2:0]  thr_q;
	logic [NST-1:0] v_q;
	logic [NST-1:0] en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= (EW-1)'(1);
		end else if (cfg_we) begin
			thr_q <= cfg_data;
		end
	end

	// a stage loads when empty or when the one after it moves on
	always_comb begin
		en[NST-1] = !v_q[NST-1] || res.ready;
		for (int k = NST - 2; k >= 0; k--)
			en[k] = !v_q[k] || en[k+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			if (en[0])
				v_q[0] <= mat.valid;
			for (int k = 1; k < NST; k++)
				if (en[k])
					v_q[k] <= v_q[k-1];
		end
	end

	assign mat.ready = en[0];

	mat_t a;
	assign a[0] = mat.a00;
	assign a[1] = mat.a01;
	assign a[2] = mat.a02;
	assign a[3] = mat.a10;
	assign a[4] = mat.a11;
	assign a[5] = mat.a12;
	assign a[6] = mat.a20;
	assign a[7] = mat.a21;
	assign a[8] = mat.a22;

	cr_t  cr [9];
	det_t det;

	mi_cofactor u_cofactor (
		.clk (clk),
		.en  (en[FRONT_ST-1:0]),
		.a   (a),
		.cr  (cr),
		.det (det)
	);

	logic [EW-1:0] quo [9];
	logic [8:0]    lsat;

	// lane for inverse (i, j) divides cross product j, component i
	for (genvar o = 0; o < 9; o++) begin : g_lane
		mi_div_lane u_lane (
			.clk (clk),
			.en  (en[NST-1:FRONT_ST]),
			.cr  (cr[(o % 3) * 3 + (o / 3)]),
			.det (det),
			.quo (quo[o]),
			.sat (lsat[o])
		);
	end

	logic [DMW-1:0] dmag;
	logic [RW-1:0]  drnd;
	logic [RW-1:0]  dlim;
	side_t          side_n;
	side_t          side_s [LANE_ST];

	always_comb begin
		dmag = det[DETW-1] ? DMW'(-det) : DMW'(det);
		drnd = RW'(dmag >> (2 * FB)) + RW'(dmag[2*FB-1]);
		dlim = (RW'(1) << (EW-1)) - RW'(!det[DETW-1]);
		side_n.sing = dmag <= DMW'({thr_q, {(2*FB){1'b0}}});
		side_n.dsat = drnd > dlim;
		if (side_n.dsat)
			side_n.dval = det[DETW-1] ? {1'b1, {(EW-1){1'b0}}} : {1'b0, {(EW-1){1'b1}}};
		else
			side_n.dval = det[DETW-1] ? EW'(-drnd) : EW'(drnd);
	end

	always_ff @(posedge clk) begin
		if (en[FRONT_ST])
			side_s[0] <= side_n;
		for (int k = 1; k < LANE_ST; k++)
			if (en[FRONT_ST+k])
				side_s[k] <= side_s[k-1];
	end

	side_t side_o;
	assign side_o = side_s[LANE_ST-1];

	assign res.valid = v_q[NST-1];
	assign res.i00 = side_o.sing ? '0 : quo[0];
	assign res.i01 = side_o.sing ? '0 : quo[1];
	assign res.i02 = side_o.sing ? '0 : quo[2];
	assign res.i10 = side_o.sing ? '0 : quo[3];
	assign res.i11 = side_o.sing ? '0 : quo[4];
	assign res.i12 = side_o.sing ? '0 : quo[5];
	assign res.i20 = side_o.sing ? '0 : quo[6];
	assign res.i21 = side_o.sing ? '0 : quo[7];
	assign res.i22 = side_o.sing ? '0 : quo[8];
	assign res.det_value = side_o.dval;
	assign res.singular = side_o.sing;
	assign res.saturated = side_o.dsat || (!side_o.sing && (|lsat));

endmodule
`default_nettype wire

// ===== src/mi_cofactor.sv =====
`default_nettype none
module mi_cofactor (
	input  wire logic                           clk,
	input  wire logic [mi_pkg::FRONT_ST-1:0]    en,
	input  mi_pkg::mat_t                        a,
	output mi_pkg::cr_t                         cr [9],
	output mi_pkg::det_t                        det
);
	import mi_pkg::*;

	logic signed [PW-1:0]  prod_s1 [18];
	elem_t                 row0_s1 [3];
	cr_t                   cr_s2 [9];
	elem_t                 row0_s2 [3];
	logic signed [PPW-1:0] pl_s3 [3];
	logic signed [PPW-1:0] ph_s3 [3];
	cr_t                   cr_s3 [9];
	det_t                  term_s4 [3];
	cr_t                   cr_s4 [9];
	det_t                  det_s5;
	cr_t                   cr_s5 [9];

	// six products per cross-product row
	for (genvar i = 0; i < 3; i++) begin : g_row
		localparam int P = (i + 1) % 3;
		localparam int Q = (i + 2) % 3;
		always_ff @(posedge clk) begin
			if (en[0]) begin
				prod_s1[i*6+0] <= a[P*3+1] * a[Q*3+2];
				prod_s1[i*6+1] <= a[P*3+2] * a[Q*3+1];
				prod_s1[i*6+2] <= a[P*3+2] * a[Q*3+0];
				prod_s1[i*6+3] <= a[P*3+0] * a[Q*3+2];
				prod_s1[i*6+4] <= a[P*3+0] * a[Q*3+1];
				prod_s1[i*6+5] <= a[P*3+1] * a[Q*3+0];
				row0_s1[i] <= a[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			for (int k = 0; k < 9; k++)
				cr_s2[k] <= CRW'(prod_s1[2*k]) - CRW'(prod_s1[2*k+1]);
			row0_s2 <= row0_s1;
		end
	end

	// row-0 products split into low and high halves of the cross product
	always_ff @(posedge clk) begin
		if (en[2]) begin
			for (int j = 0; j < 3; j++) begin
				pl_s3[j] <= PPW'(row0_s2[j]) * PPW'($signed({1'b0, cr_s2[j][EW-1:0]}));
				ph_s3[j] <= PPW'(row0_s2[j]) * PPW'($signed(cr_s2[j][CRW-1:EW]));
			end
			cr_s3 <= cr_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en[3]) begin
			for (int j = 0; j < 3; j++)
				term_s4[j] <= (DETW'(ph_s3[j]) <<< EW) + DETW'(pl_s3[j]);
			cr_s4 <= cr_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en[4]) begin
			det_s5 <= term_s4[0] + term_s4[1] + term_s4[2];
			cr_s5 <= cr_s4;
		end
	end

	assign cr = cr_s5;
	assign det = det_s5;

endmodule
`default_nettype wire

// ===== src/mi_div_lane.sv =====
`default_nettype none
module mi_div_lane (
	input  wire logic                        clk,
	input  wire logic [mi_pkg::LANE_ST-1:0]  en,
	input  mi_pkg::cr_t                      cr,
	input  mi_pkg::det_t                     det,
	output logic [mi_pkg::EW-1:0]            quo,
	output logic                             sat
);
	import mi_pkg::*;

	logic [DMW-1:0] rem_s [QW+1];
	logic [DMW-1:0] d_s   [QW+1];
	logic [QW-1:0]  nlo_s [QW+1];
	logic [QW-1:0]  q_s   [QW+1];
	logic           neg_s [QW+1];
	logic           ovf_s [QW+1];

	logic [CRMW-1:0]      cr_mag;
	logic [NUMW-1:0]      num;
	logic [DMW-1:0]       d_mag;
	logic [NUMW-QW-1:0]   rem0;
	logic                 ovf0;

	always_comb begin
		cr_mag = cr[CRW-1] ? CRMW'(-cr) : CRMW'(cr);
		num = {cr_mag, {(2*FB){1'b0}}};
		d_mag = det[DETW-1] ? DMW'(-det) : DMW'(det);
		rem0 = num[NUMW-1:QW];
		ovf0 = DMW'(rem0) >= d_mag;
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			rem_s[0] <= DMW'(rem0);
			d_s[0] <= d_mag;
			nlo_s[0] <= num[QW-1:0];
			q_s[0] <= '0;
			neg_s[0] <= cr[CRW-1] ^ det[DETW-1];
			ovf_s[0] <= ovf0;
		end
	end

	// one restoring step per stage
	for (genvar k = 1; k <= QW; k++) begin : g_step
		logic [DMW:0]  trial;
		logic          take;
		logic [QW-1:0] qn;
		always_comb begin
			trial = {rem_s[k-1], nlo_s[k-1][QW-k]};
			take = trial >= {1'b0, d_s[k-1]};
			qn = q_s[k-1];
			qn[QW-k] = take;
		end
		always_ff @(posedge clk) begin
			if (en[k]) begin
				rem_s[k] <= take ? DMW'(trial - {1'b0, d_s[k-1]}) : trial[DMW-1:0];
				d_s[k] <= d_s[k-1];
				nlo_s[k] <= nlo_s[k-1];
				q_s[k] <= qn;
				neg_s[k] <= neg_s[k-1];
				ovf_s[k] <= ovf_s[k-1];
			end
		end
	end

	logic [QW:0]   qr;
	logic [QW:0]   lim;
	logic          sat_n;
	logic [EW-1:0] val_n;

	// round half away from zero, then clip
	always_comb begin
		qr = {1'b0, q_s[QW]} + (QW+1)'({rem_s[QW], 1'b0} >= {1'b0, d_s[QW]});
		lim = ((QW+1)'(1) << (EW-1)) - (QW+1)'(!neg_s[QW]);
		sat_n = ovf_s[QW] || (qr > lim);
		if (sat_n)
			val_n = neg_s[QW] ? {1'b1, {(EW-1){1'b0}}} : {1'b0, {(EW-1){1'b1}}};
		else
			val_n = neg_s[QW] ? EW'(-qr) : EW'(qr);
	end

	always_ff @(posedge clk) begin
		if (en[QW+1]) begin
			quo <= val_n;
			sat <= sat_n;
		end
	end

endmodule
`default_nettype wire

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
	import mi_pkg::*;

	localparam int LATENCY = 45;
	localparam longint LIMIT = 600000;

	typedef logic signed [199:0] wide_t;

	typedef struct {
		logic [EW-1:0] inv [9];
		logic [EW-1:0] det;
		logic sing;
		logic sat;
	} inv_res_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [EW-2:0] cfg_data;

	mi_mat_if mat_if ();
	mi_res_if res_if ();

	matrix3x3_inverse_determinant dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_data(cfg_data),
		.mat(mat_if),
		.res(res_if)
	);

	inv_res_t pending_inverses [$];
	logic [EW-2:0] threshold;
	int idle_pct;
	int stall_pct;
	int errors;
	int sent;
	int checked;
	int singular_seen;
	int sat_seen;
	longint cycles;

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	always @(negedge clk) begin
		res_if.ready = ($urandom_range(99) >= stall_pct);
	end

	// rounded quotient, ties away from zero, clipped to the element range
	function automatic logic [EW-1:0] div_round(input wide_t num, input wide_t den,
			inout logic sat);
		logic neg;
		logic [199:0] n;
		logic [199:0] d;
		logic [199:0] q;
		logic [199:0] r;
		logic [199:0] lim;
		neg = (num < 0) != (den < 0);
		n = (num < 0) ? -num : num;
		d = (den < 0) ? -den : den;
		if (d == 0)
			return '0;
		q = n / d;
		r = n % d;
		if ((r << 1) >= d)
			q = q + 1;
		lim = neg ? (200'd1 << (EW - 1)) : ((200'd1 << (EW - 1)) - 1);
		if (q > lim) begin
			sat = 1'b1;
			return neg ? {1'b1, {(EW-1){1'b0}}} : {1'b0, {(EW-1){1'b1}}};
		end
		return neg ? -q[EW-1:0] : q[EW-1:0];
	endfunction

	function automatic inv_res_t predict_inverse(input elem_t m [9]);
		inv_res_t e;
		wide_t a [3][3];
		wide_t cr [3][3];
		wide_t det;
		wide_t mag;
		logic sat;
		int p;
		int q;
		sat = 1'b0;
		for (int i = 0; i < 9; i++)
			a[i / 3][i % 3] = wide_t'(m[i]);
		for (int i = 0; i < 3; i++) begin
			p = (i + 1) % 3;
			q = (i + 2) % 3;
			cr[i][0] = a[p][1] * a[q][2] - a[p][2] * a[q][1];
			cr[i][1] = a[p][2] * a[q][0] - a[p][0] * a[q][2];
			cr[i][2] = a[p][0] * a[q][1] - a[p][1] * a[q][0];
		end
		det = a[0][0] * cr[0][0] + a[0][1] * cr[0][1] + a[0][2] * cr[0][2];
		mag = (det < 0) ? -det : det;
		e.sing = mag <= (wide_t'({1'b0, threshold}) <<< (2 * FB));
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++)
				e.inv[i * 3 + j] = e.sing ? '0 :
					div_round(cr[j][i] <<< (2 * FB), det, sat);
		e.det = div_round(det, wide_t'(1) <<< (2 * FB), sat);
		e.sat = sat;
		return e;
	endfunction

	task automatic send_matrix(input elem_t m [9]);
		@(negedge clk);
		if ($urandom_range(99) < idle_pct) begin
			mat_if.valid = 1'b0;
			do @(negedge clk); while ($urandom_range(99) < idle_pct);
		end
		mat_if.valid = 1'b1;
		{mat_if.a00, mat_if.a01, mat_if.a02} = {m[0], m[1], m[2]};
		{mat_if.a10, mat_if.a11, mat_if.a12} = {m[3], m[4], m[5]};
		{mat_if.a20, mat_if.a21, mat_if.a22} = {m[6], m[7], m[8]};
		do @(posedge clk); while (!mat_if.ready);
		pending_inverses.push_back(predict_inverse(m));
		sent++;
	endtask

	task automatic drain;
		@(negedge clk);
		mat_if.valid = 1'b0;
		while (pending_inverses.size() != 0)
			@(posedge clk);
		repeat (LATENCY) @(posedge clk);
	endtask

	task automatic write_threshold(input logic [EW-2:0] value);
		drain();
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_data = value;
		@(negedge clk);
		cfg_we = 1'b0;
		threshold = value;
	endtask

	always @(posedge clk) begin
		inv_res_t e;
		if (arst_n && res_if.valid && res_if.ready) begin
			if (pending_inverses.size() == 0) begin
				$error("result beat with nothing expected");
				errors++;
			end else begin
				e = pending_inverses.pop_front();
				checked++;
				singular_seen += e.sing;
				sat_seen += e.sat;
				if (res_if.i00 !== e.inv[0]) begin
					$error("i00 exp %h got %h", e.inv[0], res_if.i00); errors++; end
				if (res_if.i01 !== e.inv[1]) begin
					$error("i01 exp %h got %h", e.inv[1], res_if.i01); errors++; end
				if (res_if.i02 !== e.inv[2]) begin
					$error("i02 exp %h got %h", e.inv[2], res_if.i02); errors++; end
				if (res_if.i10 !== e.inv[3]) begin
					$error("i10 exp %h got %h", e.inv[3], res_if.i10); errors++; end
				if (res_if.i11 !== e.inv[4]) begin
					$error("i11 exp %h got %h", e.inv[4], res_if.i11); errors++; end
				if (res_if.i12 !== e.inv[5]) begin
					$error("i12 exp %h got %h", e.inv[5], res_if.i12); errors++; end
				if (res_if.i20 !== e.inv[6]) begin
					$error("i20 exp %h got %h", e.inv[6], res_if.i20); errors++; end
				if (res_if.i21 !== e.inv[7]) begin
					$error("i21 exp %h got %h", e.inv[7], res_if.i21); errors++; end
				if (res_if.i22 !== e.inv[8]) begin
					$error("i22 exp %h got %h", e.inv[8], res_if.i22); errors++; end
				if (res_if.det_value !== e.det) begin
					$error("det_value exp %h got %h", e.det, res_if.det_value); errors++; end
				if (res_if.singular !== e.sing) begin
					$error("singular exp %b got %b", e.sing, res_if.singular);
					errors++;
				end
				if (res_if.saturated !== e.sat) begin
					$error("saturated exp %b got %b", e.sat, res_if.saturated); errors++; end
			end
		end
	end

	function automatic elem_t rand_elem(input int kind);
		case (kind)
			0: return elem_t'($signed($urandom_range(524288)) - 262144);
			1: return elem_t'($urandom);
			default: begin
				case ($urandom_range(5))
					0: return {1'b1, {(EW-1){1'b0}}};
					1: return {1'b0, {(EW-1){1'b1}}};
					2: return '0;
					3: return -1;
					4: return 1;
					default: return elem_t'(65536);
				endcase
			end
		endcase
	endfunction

	task automatic send_diag(input elem_t x);
		elem_t m [9];
		m = '{x, 0, 0, 0, 65536, 0, 0, 0, 65536};
		send_matrix(m);
	endtask

	task automatic test_directed;
		elem_t m [9];
		send_diag(65536);
		send_diag(1);
		send_diag(2);
		send_diag(-1);
		send_diag(-2);
		send_diag(3);
		send_diag(0);
		send_diag({1'b1, {(EW-1){1'b0}}});
		send_diag({1'b0, {(EW-1){1'b1}}});
		for (int i = 0; i < 9; i++) m[i] = {1'b0, {(EW-1){1'b1}}};
		send_matrix(m);
		for (int i = 0; i < 9; i++) m[i] = {1'b1, {(EW-1){1'b0}}};
		send_matrix(m);
		for (int i = 0; i < 9; i++) m[i] = (i % 4 == 0) ? {1'b1, {(EW-1){1'b0}}} :
			{1'b0, {(EW-1){1'b1}}};
		send_matrix(m);
		m = '{0, 65536, 0, 0, 0, 65536, 65536, 0, 0};
		send_matrix(m);
		m = '{131072, 65536, 0, 65536, 131072, 65536, 0, 65536, 131072};
		send_matrix(m);
		m = '{196608, 0, 0, 0, 196608, 0, 0, 0, -196608};
		send_matrix(m);
	endtask

	task automatic test_random(input int count, input int idle, input int stall,
			input bit hold_off);
		elem_t m [9];
		int kind;
		idle_pct = idle;
		stall_pct = stall;
		for (int n = 0; n < count; n++) begin
			kind = $urandom_range(9);
			for (int i = 0; i < 9; i++)
				m[i] = rand_elem(kind < 6 ? 0 : (kind < 8 ? 1 : $urandom_range(2)));
			// dependent rows give an exactly singular matrix
			if ($urandom_range(9) == 0)
				for (int i = 0; i < 3; i++) m[6 + i] = m[i];
			send_matrix(m);
			if (hold_off && n == count / 2)
				drain();
		end
	endtask

	task automatic test_thresholds;
		write_threshold(0);
		idle_pct = 0;
		stall_pct = 0;
		send_diag(1);
		send_diag(-1);
		write_threshold({(EW-1){1'b1}});
		send_diag(65536);
		send_diag({1'b0, {(EW-1){1'b1}}});
		send_diag({1'b1, {(EW-1){1'b0}}});
		write_threshold(1);
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_data = '0;
		mat_if.valid = 1'b0;
		{mat_if.a00, mat_if.a01, mat_if.a02} = '0;
		{mat_if.a10, mat_if.a11, mat_if.a12} = '0;
		{mat_if.a20, mat_if.a21, mat_if.a22} = '0;
		res_if.ready = 1'b1;
		threshold = 1;
		idle_pct = 0;
		stall_pct = 0;
		errors = 0;
		sent = 0;
		checked = 0;
		singular_seen = 0;
		sat_seen = 0;
		cycles = 0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_directed();
		test_thresholds();
		test_random(280, 0, 0, 1'b0);
		write_threshold(0);
		test_random(280, 80, 0, 1'b1);
		write_threshold(31'($urandom_range(65536)));
		test_random(280, 0, 80, 1'b0);
		write_threshold({(EW-1){1'b1}});
		test_random(40, 35, 35, 1'b0);
		write_threshold(31'($urandom));
		test_random(240, 35, 35, 1'b0);
		drain();
		$display("covered %0d matrices, %0d results checked", sent, checked);
		$display("%0d singular, %0d saturated, over five thresholds", singular_seen,
			sat_seen);
		if (errors == 0 && pending_inverses.size() == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
`default_nettype wire
